// ===== design/grm_pkg.sv =====
`timescale 1ns / 1ps

package grm_pkg;

    localparam int MAX_N_DEFAULT = 16;
    localparam int SIZE_W        = 5;
    localparam int COST_W        = 17;
    localparam int TOTAL_W       = 20;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(16);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

    typedef logic signed [COST_W-1:0] cost_t;

    typedef struct packed {
        logic [3:0]         row_index;
        logic [3:0]         column_index;
        logic               assigned;
        logic [15:0]        chosen_cost;
        logic [TOTAL_W-1:0] running_total;
        logic               last_row;
    } result_t;

endpackage

// ===== design/stream_if.sv =====
`timescale 1ns / 1ps

interface stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/greedy_row_min_assignment.sv =====
// Flow: an entry is registered on acceptance and processed once the result register is
//   free; the result of a row's last entry is registered in out_reg and shown on results.
// Throughput: one entry per cycle, sustained while results are taken; set by the single
//   compare-and-update of the row minimum against the used-column mask.
// Reset (rst_n, async, active low): matrix size 16, counters, used marks and total clear.
`timescale 1ns / 1ps

module greedy_row_min_assignment #(
    parameter int MAX_N = grm_pkg::MAX_N_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [grm_pkg::SIZE_W-1:0]  cfg_wr_data,
    stream_if.sink                      entries,
    stream_if.source                    results
);

    localparam int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CMP_W = 7;

    logic [grm_pkg::SIZE_W-1:0]  size_reg;
    logic                        in_valid_reg;
    grm_pkg::cost_t              cost_reg;
    logic [MAX_N-1:0]            used_reg;
    logic [15:0]                 best_cost_reg;
    logic [CW-1:0]               best_col_reg;
    logic                        found_reg;
    logic [CW-1:0]               col_reg;
    logic [CW-1:0]               row_reg;
    logic [grm_pkg::TOTAL_W-1:0] total_reg;
    logic                        out_valid_reg;
    grm_pkg::result_t            out_reg;

    logic [CW:0]                 n_act;
    logic                        out_free;
    logic                        advance;
    logic                        eligible;
    logic                        take;
    logic [15:0]                 cand_cost;
    logic [CW-1:0]               cand_col;
    logic                        cand_found;
    logic                        row_end;
    logic                        last_row;
    logic [grm_pkg::TOTAL_W:0]   total_sum;
    logic [grm_pkg::TOTAL_W-1:0] total_next;

    // Out-of-range sizes: zero acts as one, above MAX_N acts as MAX_N.
    always_comb
    begin
        if (size_reg == '0)
            n_act = (CW+1)'(1);
        else if ({2'b00, size_reg} > CMP_W'(MAX_N))
            n_act = (CW+1)'(MAX_N);
        else
            n_act = (CW+1)'(size_reg);
    end

    assign out_free      = !out_valid_reg || results.ready;
    assign advance       = in_valid_reg && out_free;
    assign entries.ready = !in_valid_reg || out_free;

    always_comb
    begin
        eligible   = !cost_reg[grm_pkg::COST_W-1] && !used_reg[col_reg];
        take       = eligible && (!found_reg || (cost_reg[15:0] < best_cost_reg));
        cand_cost  = take ? cost_reg[15:0] : best_cost_reg;
        cand_col   = take ? col_reg : best_col_reg;
        cand_found = found_reg || take;
        row_end    = ({1'b0, col_reg} + (CW+1)'(1)) >= n_act;
        last_row   = ({1'b0, row_reg} + (CW+1)'(1)) >= n_act;
        total_sum  = {1'b0, total_reg} + (grm_pkg::TOTAL_W+1)'(cand_found ? cand_cost : 16'd0);
        total_next = total_sum[grm_pkg::TOTAL_W] ? grm_pkg::TOTAL_MAX
                                                 : total_sum[grm_pkg::TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (entries.ready)
        begin
            in_valid_reg <= entries.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entries.ready && entries.valid)
            cost_reg <= entries.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= grm_pkg::SIZE_RESET;
            used_reg      <= '0;
            best_cost_reg <= '0;
            best_col_reg  <= '0;
            found_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            total_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            size_reg      <= cfg_wr_data;
            used_reg      <= '0;
            best_cost_reg <= '0;
            best_col_reg  <= '0;
            found_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            total_reg     <= '0;
        end
        else if (advance)
        begin
            if (row_end)
            begin
                best_cost_reg <= '0;
                best_col_reg  <= '0;
                found_reg     <= 1'b0;
                col_reg       <= '0;
                if (last_row)
                begin
                    used_reg  <= '0;
                    row_reg   <= '0;
                    total_reg <= '0;
                end
                else
                begin
                    row_reg   <= row_reg + CW'(1);
                    total_reg <= total_next;
                    if (cand_found)
                        used_reg <= used_reg | (MAX_N'(1) << cand_col);
                end
            end
            else
            begin
                best_cost_reg <= cand_cost;
                best_col_reg  <= cand_col;
                found_reg     <= cand_found;
                col_reg       <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && row_end)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && row_end)
        begin
            out_reg.row_index     <= 4'(row_reg);
            out_reg.column_index  <= cand_found ? 4'(cand_col) : 4'd0;
            out_reg.assigned      <= cand_found;
            out_reg.chosen_cost   <= cand_found ? cand_cost : 16'd0;
            out_reg.running_total <= total_next;
            out_reg.last_row      <= last_row;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    // A finished matrix leaves no marks, no total and restarts at row 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && row_end && last_row && !cfg_wr_en)
            |=> (used_reg == '0 && total_reg == '0 && row_reg == '0))
        else $error("matrix state not cleared after last row");

    // Each completed row marks at most one column.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) <= int'(row_reg))
        else $error("more used columns than completed rows");

    // Counters stay inside the active size.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < n_act) && ({1'b0, row_reg} < n_act))
        else $error("counter beyond active matrix size");

    // Within a matrix the total never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && row_end && !last_row && !cfg_wr_en) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased mid-matrix");

    // Unassigned rows report zero column and zero cost.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.assigned)
            |-> (out_reg.column_index == 4'd0 && out_reg.chosen_cost == 16'd0))
        else $error("unassigned row carries column or cost");

endmodule

// ===== tb/grm_checker.sv =====
`timescale 1ns / 1ps

module grm_checker
    import grm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              entry_valid,
    input  logic              entry_ready,
    input  cost_t             entry_cost,
    input  logic              result_valid,
    input  logic              result_ready,
    input  result_t           result_beat,
    output int                outstanding,
    output int                fail_count
);

    localparam int MAX_N = MAX_N_DEFAULT;

    logic [SIZE_W-1:0] size_reg;
    logic [MAX_N-1:0]  used_cols;
    logic [15:0]       min_cost;
    int                min_col;
    logic              min_found;
    int                col_cnt;
    int                row_cnt;
    int                cost_sum;
    int                span;
    int                errors;
    result_t           assignments_q[$];
    result_t           want;

    function automatic int differs(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v === act_v)
        begin
            return 0;
        end
        $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
        return 1;
    endfunction

    task automatic clear_row();
        min_cost  = '0;
        min_col   = 0;
        min_found = 1'b0;
        col_cnt   = 0;
    endtask

    task automatic clear_matrix();
        clear_row();
        row_cnt   = 0;
        used_cols = '0;
        cost_sum  = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = SIZE_RESET;
            clear_matrix();
            assignments_q.delete();
            errors = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            // check before predicting so a premature beat cannot match this edge's entry
            if (result_valid && result_ready)
            begin
                if (assignments_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", result_beat);
                    errors++;
                end
                else
                begin
                    want = assignments_q.pop_front();
                    errors += differs("row_index", want.row_index, result_beat.row_index);
                    errors += differs("column_index", want.column_index,
                                      result_beat.column_index);
                    errors += differs("assigned", want.assigned, result_beat.assigned);
                    errors += differs("chosen_cost", want.chosen_cost, result_beat.chosen_cost);
                    errors += differs("running_total", want.running_total,
                                      result_beat.running_total);
                    errors += differs("last_row", want.last_row, result_beat.last_row);
                end
            end

            if (cfg_wr_en)
            begin
                size_reg = cfg_wr_data;
                clear_matrix();
            end

            if (entry_valid && entry_ready)
            begin
                span = (size_reg == 0) ? 1 : (size_reg > MAX_N) ? MAX_N : int'(size_reg);
                // any negative entry is forbidden, not only -1
                if (!entry_cost[COST_W-1] && !used_cols[col_cnt]
                    && (!min_found || entry_cost[15:0] < min_cost))
                begin
                    min_cost  = entry_cost[15:0];
                    min_col   = col_cnt;
                    min_found = 1'b1;
                end

                if (col_cnt + 1 < span)
                begin
                    col_cnt++;
                end
                else
                begin
                    if (min_found)
                    begin
                        used_cols[min_col] = 1'b1;
                        cost_sum += int'(min_cost);
                        if (cost_sum > int'(TOTAL_MAX))
                        begin
                            cost_sum = int'(TOTAL_MAX);
                        end
                    end
                    want.row_index     = row_cnt[3:0];
                    want.column_index  = min_found ? min_col[3:0] : 4'd0;
                    want.assigned      = min_found;
                    want.chosen_cost   = min_found ? min_cost : 16'd0;
                    want.running_total = cost_sum[TOTAL_W-1:0];
                    want.last_row      = (row_cnt + 1 >= span);
                    assignments_q.insert(assignments_q.size(), want);
                    if (want.last_row)
                    begin
                        clear_matrix();
                    end
                    else
                    begin
                        row_cnt++;
                        clear_row();
                    end
                end
            end

            outstanding <= assignments_q.size();
            fail_count  <= errors;
        end
    end

endmodule

// ===== tb/greedy_row_min_assignment_tb.sv =====
`timescale 1ns / 1ps

module greedy_row_min_assignment_tb;

    import grm_pkg::*;

    localparam int RANDOM_ITEMS = 1020;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE       = 6;
    localparam int QUIET_LIMIT  = 500;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;
    int                outstanding;
    int                fail_count;
    int                quiet_cycles;
    int                stall_left;
    bit                sender_idles;
    bit                receiver_stalls;

    stream_if #(.payload_t(cost_t))   entries_if ();
    stream_if #(.payload_t(result_t)) results_if ();

    greedy_row_min_assignment u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entries     (entries_if),
        .results     (results_if)
    );

    grm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .entry_valid  (entries_if.valid),
        .entry_ready  (entries_if.ready),
        .entry_cost   (entries_if.payload),
        .result_valid (results_if.valid),
        .result_ready (results_if.ready),
        .result_beat  (results_if.payload),
        .outstanding  (outstanding),
        .fail_count   (fail_count)
    );

    always #4 clk = ~clk;

    // receiver: random stall bursts that hold ready low
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            results_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (receiver_stalls && $urandom_range(0, 4) == 0)
        begin
            results_if.ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
        begin
            results_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (entries_if.valid && entries_if.ready)
            || (results_if.valid && results_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL greedy_row_min_assignment");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_cost(cost_t c);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            entries_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        entries_if.valid   <= 1'b1;
        entries_if.payload <= c;
        do @(posedge clk); while (!entries_if.ready);
    endtask

    task automatic drain(int extra);
        entries_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (extra) @(posedge clk);
    endtask

    // extra settle cycles cover entries still in flight that make no result
    task automatic write_size(int value);
        drain(SETTLE);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SIZE_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic cost_t random_cost();
        case ($urandom_range(0, 9))
            0, 1:    return cost_t'(-1);
            2:       return cost_t'($urandom_range(65536, 131071));
            3, 4:    return cost_t'($urandom_range(0, 7));
            5:       return cost_t'(65535);
            default: return cost_t'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int plan[$];
        int first_sizes[6];
        int phase;
        int sent;
        int span;
        int count;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        entries_if.valid   = 1'b0;
        entries_if.payload = '0;
        results_if.ready   = 1'b0;
        stall_left         = 0;
        quiet_cycles       = 0;
        sender_idles       = 1'b1;
        receiver_stalls    = 1'b1;
        first_sizes        = '{1, 31, 0, 17, 16, 2};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 16, one row: forbidden, max cost, most negative, tie on 5
        plan = '{-1, 65535, 5, -65536, 5, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 65535};
        foreach (plan[i])
        begin
            send_cost(cost_t'(plan[i]));
        end
        // abandons the size-16 matrix at row 1
        write_size(2);
        // zero-cost tie; later row finds its best column taken
        plan = '{0, 0, 0, 65535,
                 // all forbidden, then a negative that is not -1
                 -1, -1, -2, 9,
                 // second row: used column plus forbidden leaves nothing
                 4, -1, 1, -1};
        foreach (plan[i])
        begin
            send_cost(cost_t'(plan[i]));
            if (i == 5)
            begin
                drain(0);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 6)
            begin
                write_size(first_sizes[phase]);
                span = first_sizes[phase];
            end
            else
            begin
                span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(1, 8);
                write_size(span);
            end
            span = (span == 0) ? 1 : (span > MAX_N_DEFAULT) ? MAX_N_DEFAULT : span;
            if (span >= 12)
            begin
                count = span * span;
            end
            else if (span >= 4)
            begin
                count = span * span * $urandom_range(2, 4);
            end
            else
            begin
                count = span * span * $urandom_range(4, 12);
            end
            // sometimes leave a matrix half done for the next write to abandon
            if (span > 1 && $urandom_range(0, 2) == 0)
            begin
                count += $urandom_range(1, span * span - 1);
            end
            if (sent + count > RANDOM_ITEMS)
            begin
                count = RANDOM_ITEMS - sent;
            end
            if (sent + count > RANDOM_ITEMS - CALM_TAIL)
            begin
                sender_idles    = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_idles    = $urandom_range(0, 3) != 0;
                receiver_stalls = $urandom_range(0, 3) != 0;
            end
            for (int k = 0; k < count; k++)
            begin
                send_cost(random_cost());
                if (k % 97 == 50)
                begin
                    drain(0);
                end
            end
            sent += count;
            phase++;
        end

        drain(10);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS greedy_row_min_assignment");
        end
        else
        begin
            $display("FAIL greedy_row_min_assignment");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/grm_pkg.sv
design/stream_if.sv
design/greedy_row_min_assignment.sv
tb/grm_checker.sv
tb/greedy_row_min_assignment_tb.sv
